>>> rtl/pda_pkg.sv
// Shared types, constants and the tangent threshold table for the direction angle unit.
package pda_pkg;

    localparam int CoordW      = 16;
    localparam int AbsW        = CoordW + 1;
    localparam int FracW       = 16;
    localparam int ThrW        = 23;
    localparam int ProdW       = AbsW + ThrW;
    localparam int NumThr      = 89;
    localparam int SearchSteps = 7;
    localparam int BaseW       = SearchSteps;
    localparam int TableSize   = 1 << SearchSteps;
    localparam int DegW        = 10;
    localparam int QBits       = 30;
    localparam int AngScale    = 57;
    localparam int TaylorTerms = 12;

    localparam logic signed [DegW-1:0] DegNone  = -DegW'(1);
    localparam logic signed [DegW-1:0] DegRight = DegW'(0);
    localparam logic signed [DegW-1:0] DegUp    = DegW'(90);
    localparam logic signed [DegW-1:0] DegLeft  = DegW'(180);
    localparam logic signed [DegW-1:0] DegDown  = DegW'(270);
    localparam logic signed [DegW-1:0] DegFull  = DegW'(360);

    typedef enum logic [2:0] {
        KIND_COINCIDENT,
        KIND_UP,
        KIND_DOWN,
        KIND_RIGHT,
        KIND_LEFT,
        KIND_GENERAL
    } dir_kind_t;

    typedef struct packed {
        dir_kind_t           kind;
        logic                dx_neg;
        logic                dy_neg;
        logic [AbsW-1:0]     adx;
        logic [AbsW-1:0]     ady;
        logic [BaseW-1:0]    base;
    } pda_word_t;

    typedef logic [TableSize-1:0][ThrW-1:0] thr_table_t;

    // Restoring long division, used only while the table is elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry k holds tan(k/57) in Q16, rounded up, from Q30 Taylor sums.
    function automatic thr_table_t build_thr_table();
        thr_table_t  tbl;
        logic [63:0] th;
        logic [63:0] ts;
        logic [63:0] tc;
        longint      s;
        longint      c;
        logic [63:0] num;
        logic [63:0] quo;
        tbl = '0;
        for (int k = 1; k <= NumThr; k++)
        begin
            th = udiv64((64'(k) << QBits) + 64'(AngScale / 2), 64'(AngScale));
            ts = th;
            tc = 64'(1) << QBits;
            s  = longint'(th);
            c  = longint'(tc);
            for (int n = 1; n <= TaylorTerms; n++)
            begin
                ts = (ts * th) >> QBits;
                ts = (ts * th) >> QBits;
                ts = udiv64(ts, 64'((2 * n) * (2 * n + 1)));
                tc = (tc * th) >> QBits;
                tc = (tc * th) >> QBits;
                tc = udiv64(tc, 64'((2 * n - 1) * (2 * n)));
                if (n % 2 == 1)
                begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end
                else
                begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            if (s < 0)
            begin
                s = 0;
            end
            if (c < 1)
            begin
                c = 1;
            end
            num    = (64'(s) << FracW) + 64'(c) - 64'(1);
            quo    = udiv64(num, 64'(c));
            tbl[k] = quo[ThrW-1:0];
        end
        return tbl;
    endfunction

    localparam thr_table_t ThrTable = build_thr_table();

endpackage

>>> rtl/pda_prep.sv
// Input stage: classifies the point pair and forms the wrapped absolute differences.
module pda_prep
    import pda_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CoordW-1:0] from_x,
    input  logic signed [CoordW-1:0] from_y,
    input  logic signed [CoordW-1:0] to_x,
    input  logic signed [CoordW-1:0] to_y,
    output logic                     out_valid,
    output pda_word_t                out_word,
    input  logic                     out_ready
);

    logic              valid_reg;
    logic              valid_next;
    pda_word_t         word_reg;
    pda_word_t         word_next;
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dx = to_x - from_x;
        dy = to_y - from_y;
        word_next.dx_neg = dx[CoordW-1];
        word_next.dy_neg = dy[CoordW-1];
        word_next.adx    = dx[CoordW-1] ? (AbsW'(0) - {dx[CoordW-1], dx}) : {1'b0, dx};
        word_next.ady    = dy[CoordW-1] ? (AbsW'(0) - {dy[CoordW-1], dy}) : {1'b0, dy};
        word_next.base   = '0;
        if (from_x == to_x && from_y == to_y)
        begin
            word_next.kind = KIND_COINCIDENT;
        end
        else if (from_x == to_x)
        begin
            word_next.kind = (from_y > to_y) ? KIND_UP : KIND_DOWN;
        end
        else if (from_y == to_y)
        begin
            word_next.kind = (from_x < to_x) ? KIND_RIGHT : KIND_LEFT;
        end
        else
        begin
            word_next.kind = KIND_GENERAL;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> rtl/pda_search_stage.sv
// One step of the binary search for the base angle over the threshold table.
module pda_search_stage
    import pda_pkg::*;
#(
    parameter int Step = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pda_word_t in_word,
    output logic      out_valid,
    output pda_word_t out_word,
    input  logic      out_ready
);

    localparam logic [BaseW-1:0] StepBit = BaseW'(1) << Step;

    logic             valid_reg;
    logic             valid_next;
    pda_word_t        word_reg;
    pda_word_t        word_next;
    logic [BaseW-1:0] cand;
    logic [ProdW-1:0] prod;
    logic [ProdW-1:0] lhs;
    logic             take;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        cand      = in_word.base | StepBit;
        prod      = ProdW'(in_word.adx) * ProdW'(ThrTable[cand]);
        lhs       = ProdW'({in_word.ady, {FracW{1'b0}}});
        take      = (cand <= BaseW'(NumThr)) && (lhs >= prod);
        word_next = in_word;
        if (take)
        begin
            word_next.base = cand;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> rtl/pda_map.sv
// Output stage: maps the base angle by quadrant and holds the result word.
module pda_map
    import pda_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pda_word_t              in_word,
    output logic                   out_valid,
    output logic signed [DegW-1:0] out_deg,
    input  logic                   out_ready
);

    logic                   valid_reg;
    logic                   valid_next;
    logic signed [DegW-1:0] deg_reg;
    logic signed [DegW-1:0] deg_next;
    logic signed [DegW-1:0] base_ext;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        base_ext = DegW'(in_word.base);
        case (in_word.kind)
            KIND_COINCIDENT: deg_next = DegNone;
            KIND_UP:         deg_next = DegUp;
            KIND_DOWN:       deg_next = DegDown;
            KIND_RIGHT:      deg_next = DegRight;
            KIND_LEFT:       deg_next = DegLeft;
            KIND_GENERAL:
            begin
                if (!in_word.dx_neg)
                begin
                    deg_next = in_word.dy_neg ? base_ext : (DegFull - base_ext);
                end
                else
                begin
                    deg_next = in_word.dy_neg ? (DegLeft - base_ext) : (DegLeft + base_ext);
                end
            end
            default:         deg_next = DegNone;
        endcase
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            deg_reg <= deg_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_deg   = deg_reg;

endmodule

>>> rtl/point_direction_angle_unit.sv
// Top level of the direction angle unit: input stage, search pipeline and output stage.
//
//  Channel  Handshake             Payload
//  in       in_valid / in_stall   from_x, from_y, to_x, to_y (signed 16 bits each)
//  out      out_valid / out_stall direction_deg (signed 10 bits)
//
//  One word is accepted every cycle while in_stall is low; a word is registered by the input stage,
//  the seven binary search steps, one table multiply and compare each, and the output stage.
//  Reset empties every stage at once; no table fill is needed after reset.
//  A stall holds only the stages that are full behind it, so bubbles close up.
module point_direction_angle_unit
    import pda_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [CoordW-1:0] from_x,
    input  logic signed [CoordW-1:0] from_y,
    input  logic signed [CoordW-1:0] to_x,
    input  logic signed [CoordW-1:0] to_y,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DegW-1:0]   direction_deg
);

    logic      in_ready;
    logic      chain_valid [SearchSteps+1];
    logic      chain_ready [SearchSteps+1];
    pda_word_t chain_word  [SearchSteps+1];

    assign in_stall = !in_ready;

    pda_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .from_x    (from_x),
        .from_y    (from_y),
        .to_x      (to_x),
        .to_y      (to_y),
        .out_valid (chain_valid[0]),
        .out_word  (chain_word[0]),
        .out_ready (chain_ready[0])
    );

    for (genvar i = 0; i < SearchSteps; i++)
    begin : g_search
        pda_search_stage #(
            .Step (SearchSteps - 1 - i)
        ) u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_word  (chain_word[i+1]),
            .out_ready (chain_ready[i+1])
        );
    end

    pda_map u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[SearchSteps]),
        .in_ready  (chain_ready[SearchSteps]),
        .in_word   (chain_word[SearchSteps]),
        .out_valid (out_valid),
        .out_deg   (direction_deg),
        .out_ready (!out_stall)
    );

    // A stalled input means the first stage is holding a word.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> chain_valid[0])
        else $error("input stalled while the first stage is empty");

    // With the output free, every stage can move, so the input is never stalled.
    a_free_output_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while the output is free");

    // Every delivered angle lies in the range of the result.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (direction_deg >= DegNone && direction_deg <= DegFull))
        else $error("direction out of range");

endmodule

>>> verif/direction_checker.sv
// Checker that predicts the direction angle of every accepted point pair and compares results.
`timescale 1ns / 1ps

module direction_checker
    import pda_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [CoordW-1:0] from_x,
    input  logic signed [CoordW-1:0] from_y,
    input  logic signed [CoordW-1:0] to_x,
    input  logic signed [CoordW-1:0] to_y,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [DegW-1:0]   direction_deg,
    output int                       error_count,
    output int                       pending_count
);

    localparam int DegScale    = 57;
    localparam int TanFracBits = 30;
    localparam int TanSteps    = 89;
    localparam int SeriesLen   = 12;

    typedef struct {
        logic signed [CoordW-1:0] fx;
        logic signed [CoordW-1:0] fy;
        logic signed [CoordW-1:0] tx;
        logic signed [CoordW-1:0] ty;
        logic signed [DegW-1:0]   deg;
    } dir_expect_t;

    longint unsigned tan_thr [1:TanSteps];
    dir_expect_t     expected_dirs [$];

    // Each threshold is tan(k/57) in Q16, rounded up, from truncated Q30 power series.
    initial
    begin
        longint unsigned theta;
        longint unsigned sin_term;
        longint unsigned cos_term;
        longint          sin_sum;
        longint          cos_sum;
        longint unsigned num;
        for (int k = 1; k <= TanSteps; k++)
        begin
            theta    = ((64'(k) << TanFracBits) + 64'(DegScale / 2)) / 64'(DegScale);
            sin_term = theta;
            cos_term = 64'd1 << TanFracBits;
            sin_sum  = $signed(sin_term);
            cos_sum  = $signed(cos_term);
            for (int n = 1; n <= SeriesLen; n++)
            begin
                sin_term = (sin_term * theta) >> TanFracBits;
                sin_term = (sin_term * theta) >> TanFracBits;
                sin_term = sin_term / 64'((2 * n) * (2 * n + 1));
                cos_term = (cos_term * theta) >> TanFracBits;
                cos_term = (cos_term * theta) >> TanFracBits;
                cos_term = cos_term / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                begin
                    sin_sum = sin_sum - $signed(sin_term);
                    cos_sum = cos_sum - $signed(cos_term);
                end
                else
                begin
                    sin_sum = sin_sum + $signed(sin_term);
                    cos_sum = cos_sum + $signed(cos_term);
                end
            end
            if (sin_sum < 0)
            begin
                sin_sum = 0;
            end
            if (cos_sum < 1)
            begin
                cos_sum = 1;
            end
            num        = ($unsigned(sin_sum) << 16) + $unsigned(cos_sum) - 64'd1;
            tan_thr[k] = num / $unsigned(cos_sum);
        end
    end

    function automatic logic signed [DegW-1:0] predict_direction(
        input logic signed [CoordW-1:0] fx,
        input logic signed [CoordW-1:0] fy,
        input logic signed [CoordW-1:0] tx,
        input logic signed [CoordW-1:0] ty
    );
        dir_kind_t                kind;
        logic signed [CoordW-1:0] dx;
        logic signed [CoordW-1:0] dy;
        longint unsigned          adx;
        longint unsigned          ady;
        int                       base;
        int                       deg;
        dx = tx - fx;
        dy = ty - fy;
        if (fx == tx && fy == ty)
        begin
            kind = KIND_COINCIDENT;
        end
        else if (fx == tx)
        begin
            if (fy > ty)
            begin
                kind = KIND_UP;
            end
            else
            begin
                kind = KIND_DOWN;
            end
        end
        else if (fy == ty)
        begin
            if (fx < tx)
            begin
                kind = KIND_RIGHT;
            end
            else
            begin
                kind = KIND_LEFT;
            end
        end
        else
        begin
            kind = KIND_GENERAL;
        end
        case (kind)
            KIND_COINCIDENT: return DegNone;
            KIND_UP:         return DegUp;
            KIND_DOWN:       return DegDown;
            KIND_RIGHT:      return DegRight;
            KIND_LEFT:       return DegLeft;
            default:
            begin
                adx  = (dx < 0) ? 64'(-int'(dx)) : 64'(int'(dx));
                ady  = (dy < 0) ? 64'(-int'(dy)) : 64'(int'(dy));
                base = 0;
                for (int k = 1; k <= TanSteps; k++)
                begin
                    if ((ady << 16) >= adx * tan_thr[k])
                    begin
                        base = k;
                    end
                end
                if (dx > 0)
                begin
                    deg = (dy < 0) ? base : int'(DegFull) - base;
                end
                else
                begin
                    deg = (dy < 0) ? int'(DegLeft) - base : int'(DegLeft) + base;
                end
                return DegW'(deg);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dir_expect_t word;
        if (!rst_n)
        begin
            expected_dirs.delete();
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                word.fx  = from_x;
                word.fy  = from_y;
                word.tx  = to_x;
                word.ty  = to_y;
                word.deg = predict_direction(from_x, from_y, to_x, to_y);
                expected_dirs.push_back(word);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_dirs.size() == 0)
                begin
                    $display("%0t: unexpected output word: expected none, got %0d",
                             $time, direction_deg);
                    error_count <= error_count + 1;
                end
                else
                begin
                    word = expected_dirs.pop_front();
                    if (direction_deg !== word.deg)
                    begin
                        $display("%0t: direction (%0d,%0d)->(%0d,%0d): expected %0d, got %0d",
                                 $time, word.fx, word.fy, word.tx, word.ty, word.deg,
                                 direction_deg);
                        error_count <= error_count + 1;
                    end
                end
            end
            pending_count <= expected_dirs.size();
        end
    end

endmodule

>>> verif/tb.sv
// Testbench top that drives point pairs into the direction angle unit and reports the verdict.
`timescale 1ns / 1ps

module tb;
    import pda_pkg::*;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [CoordW-1:0] from_x    = '0;
    logic signed [CoordW-1:0] from_y    = '0;
    logic signed [CoordW-1:0] to_x      = '0;
    logic signed [CoordW-1:0] to_y      = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DegW-1:0]   direction_deg;
    logic                     calm      = 1'b0;
    int                       error_count;
    int                       pending_count;

    point_direction_angle_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .from_x        (from_x),
        .from_y        (from_y),
        .to_x          (to_x),
        .to_y          (to_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .direction_deg (direction_deg)
    );

    direction_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .from_x        (from_x),
        .from_y        (from_y),
        .to_x          (to_x),
        .to_y          (to_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .direction_deg (direction_deg),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 23);
    end

    task automatic send_points(
        input logic signed [CoordW-1:0] fx,
        input logic signed [CoordW-1:0] fy,
        input logic signed [CoordW-1:0] tx,
        input logic signed [CoordW-1:0] ty
    );
        while (!calm && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        from_x   <= fx;
        from_y   <= fy;
        to_x     <= tx;
        to_y     <= ty;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [CoordW-1:0] corner_coord();
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            5:       return 16'sd32766;
            6:       return 16'sd32767;
            default: return CoordW'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [CoordW-1:0] fx;
        logic signed [CoordW-1:0] fy;
        logic signed [CoordW-1:0] tx;
        logic signed [CoordW-1:0] ty;
        int                       dx;
        int                       dy;
        int                       swap;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_points(0, 0, 0, 0);
        send_points(-32768, -32768, -32768, -32768);
        send_points(32767, 32767, 32767, 32767);
        send_points(5, 10, 5, -3);
        send_points(5, -3, 5, 10);
        send_points(0, 32767, 0, -32768);
        send_points(-7, 4, 9, 4);
        send_points(9, 4, -7, 4);
        send_points(-32768, 0, 32767, 0);
        send_points(0, 0, 100, -100);
        send_points(0, 0, -100, -100);
        send_points(0, 0, 100, 100);
        send_points(0, 0, -100, 100);
        send_points(0, 0, 1000, 1);
        send_points(0, 0, 1000, -1);
        send_points(0, 0, 1, -30000);
        send_points(0, 0, -1, 30000);
        send_points(-32768, -32768, 32767, 32767);
        send_points(32767, -32768, -32768, 32767);
        send_points(0, 0, -32768, -32768);
        send_points(0, 0, -32768, 1);
        send_points(1, -1, -32768, 32767);
        send_points(0, 0, 3, -4);
        send_points(0, 0, -4, 3);

        for (int i = 0; i < 1530; i++)
        begin
            if (i == 600)
            begin
                calm <= 1'b1;
            end
            if (i == 800)
            begin
                calm <= 1'b0;
            end
            fx = CoordW'($urandom);
            fy = CoordW'($urandom);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    tx = CoordW'($urandom);
                    ty = CoordW'($urandom);
                end
                2, 3, 4:
                begin
                    dx = $urandom_range(0, 400) - 200;
                    dy = $urandom_range(0, 400) - 200;
                    tx = CoordW'(fx + dx);
                    ty = CoordW'(fy + dy);
                end
                5:
                begin
                    dx = $urandom_range(0, 8000) - 4000;
                    dy = $urandom_range(0, 8000) - 4000;
                    tx = CoordW'(fx + dx);
                    ty = CoordW'(fy + dy);
                end
                6:
                begin
                    dx   = $urandom_range(1, 32767);
                    dy   = $urandom_range(0, 6) - 3;
                    swap = $urandom_range(0, 1);
                    if ($urandom_range(0, 1))
                    begin
                        dx = -dx;
                    end
                    tx = CoordW'(fx + (swap ? dy : dx));
                    ty = CoordW'(fy + (swap ? dx : dy));
                end
                7:
                begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            tx = fx;
                            ty = fy;
                        end
                        1:
                        begin
                            tx = fx;
                            ty = CoordW'($urandom);
                        end
                        default:
                        begin
                            tx = CoordW'($urandom);
                            ty = fy;
                        end
                    endcase
                end
                8:
                begin
                    dx = $urandom_range(1, 3000);
                    dy = dx * $urandom_range(1, 4) / $urandom_range(1, 4);
                    if ($urandom_range(0, 1))
                    begin
                        dx = -dx;
                    end
                    if ($urandom_range(0, 1))
                    begin
                        dy = -dy;
                    end
                    tx = CoordW'(fx + dx);
                    ty = CoordW'(fy + dy);
                end
                default:
                begin
                    fx = corner_coord();
                    fy = corner_coord();
                    tx = corner_coord();
                    ty = corner_coord();
                end
            endcase
            send_points(fx, fy, tx, ty);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
